// ===== rtl/fenwick_tree_modular_epoch_clear_core_macros.svh =====
// ----------------------------------------------------------------------------
// fenwick tree core assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef FENWICK_TREE_MODULAR_EPOCH_CLEAR_CORE_MACROS_SVH
`define FENWICK_TREE_MODULAR_EPOCH_CLEAR_CORE_MACROS_SVH

// same-cycle implication
`define FWK_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fenwick core check failed");

// next-cycle implication
`define FWK_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fenwick core check failed");

`endif

// ===== rtl/fwk_pkg.sv =====
// ----------------------------------------------------------------------------
// fwk_pkg
// shared widths, codes, command type and modular helpers of the fenwick core
// ----------------------------------------------------------------------------
package fwk_pkg;

  localparam int OP_W  = 2;
  localparam int POS_W = 10;
  localparam int AMT_W = 30;
  localparam int SUM_W = 30;

  localparam logic [SUM_W-1:0] PRIME_MOD = 30'd1000000007;

  // operation codes on the request channel
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_PREFIX = 2'd1;
  localparam logic [OP_W-1:0] OP_RANGE  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // classified command kinds
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_NOP    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PREFIX = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RANGE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos_a;   // add position or start index of the prefix or right-end walk
    logic [POS_W-1:0]  pos_b;   // start index of the left-end walk
    logic [AMT_W-1:0]  amount;  // already reduced below the prime
  } fwk_cmd_t;

  function automatic logic [SUM_W-1:0] mod_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, PRIME_MOD}) ? SUM_W'(s - {1'b0, PRIME_MOD}) : s[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] mod_sub(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, PRIME_MOD} - {1'b0, b};
    return (a >= b) ? (a - b) : s[SUM_W-1:0];
  endfunction

endpackage

// ===== rtl/fwk_if.sv =====
// ----------------------------------------------------------------------------
// fwk channel interfaces
// valid/ready request and response channels of the fenwick core
// ----------------------------------------------------------------------------
interface fwk_req_if import fwk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] low_position;
  logic [AMT_W-1:0] amount;

  modport source (output valid, operation, position, low_position, amount, input ready);
  modport sink   (input valid, operation, position, low_position, amount, output ready);
endinterface

interface fwk_rsp_if import fwk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] sum;

  modport source (output valid, sum, input ready);
  modport sink   (input valid, sum, output ready);
endinterface

// ===== rtl/fwk_front.sv =====
// ----------------------------------------------------------------------------
// fwk_front
// accepts request words, reduces the amount and turns each into a command
// ----------------------------------------------------------------------------
module fwk_front import fwk_pkg::*; #(
  parameter int TABLE_SIZE = 1024
) (
  fwk_req_if.sink  req,
  input  logic     q_full,
  input  logic     clearing,
  output logic     push,
  output fwk_cmd_t cmd
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int WW = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam logic [WW-1:0] TSIZE = WW'(TABLE_SIZE);
  localparam logic [WW-1:0] TMAX  = WW'(TABLE_SIZE - 1);

  function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
    return (WW'(p) > TMAX) ? TMAX[POS_W-1:0] : p;
  endfunction

  logic [POS_W-1:0] low_left;

  assign req.ready = !q_full && !clearing;
  assign push      = req.valid && req.ready;

  // prefix just left of the range's left end
  assign low_left = (req.low_position == '0) ? '0 : clamp_pos(req.low_position - 1'b1);

  always_comb begin
    cmd.kind   = KIND_NOP;
    cmd.pos_a  = '0;
    cmd.pos_b  = '0;
    cmd.amount = (req.amount >= PRIME_MOD) ? (req.amount - PRIME_MOD) : req.amount;
    unique case (req.operation)
      OP_ADD: begin
        // position zero and positions past the table leave the tree alone
        if (req.position != '0 && WW'(req.position) < TSIZE) begin
          cmd.kind = KIND_ADD;
        end
        cmd.pos_a = req.position;
      end
      OP_PREFIX: begin
        cmd.kind  = KIND_PREFIX;
        cmd.pos_a = clamp_pos(req.position);
      end
      OP_RANGE: begin
        cmd.kind  = KIND_RANGE;
        cmd.pos_a = clamp_pos(req.position);
        cmd.pos_b = low_left;
      end
      OP_CLEAR: begin
        cmd.kind = KIND_CLEAR;
      end
      default: begin
        cmd.kind = KIND_NOP;
      end
    endcase
  end

endmodule

// ===== rtl/fwk_queue.sv =====
// ----------------------------------------------------------------------------
// fwk_queue
// short command queue that decouples the front from the tree walker
// ----------------------------------------------------------------------------
module fwk_queue import fwk_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fwk_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output fwk_cmd_t pop_cmd,
  output logic     not_empty
);

  fwk_cmd_t          entries [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_cmd   = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/fwk_back.sv =====
// ----------------------------------------------------------------------------
// fwk_back
// tree walker: memory of stamped partial sums, epoch counter, clear sweep
// ----------------------------------------------------------------------------
module fwk_back import fwk_pkg::*; #(
  parameter int TABLE_SIZE = 1024,
  parameter int EPOCH_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  fwk_cmd_t  q_cmd,
  output logic      q_pop,
  output logic      clearing,
  fwk_rsp_if.source rsp
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int IW = AW + 1;
  localparam int MW = EPOCH_BITS + SUM_W;
  localparam logic [IW-1:0] TSIZE = IW'(TABLE_SIZE);
  localparam logic [AW-1:0] LAST  = AW'(TABLE_SIZE - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [MW-1:0]         mem [TABLE_SIZE];
  logic [MW-1:0]         rdata;

  logic [1:0]            state;
  logic [EPOCH_BITS-1:0] epoch;
  logic [AW-1:0]         cidx;
  logic                  pend;
  logic                  second;
  logic                  out_valid;

  logic [KIND_W-1:0]     kind;
  logic [AMT_W-1:0]      amount;
  logic [POS_W-1:0]      pos_b;
  logic [IW-1:0]         idx;
  logic [AW-1:0]         widx;
  logic [SUM_W-1:0]      acc;
  logic [SUM_W-1:0]      acc_r;
  logic [SUM_W-1:0]      out_sum;

  logic                  walk_add;
  logic                  active;
  logic [IW-1:0]         lowbit;
  logic [IW-1:0]         idx_step;
  logic                  rd_en;
  logic                  walk_done;
  logic                  slot_free;
  logic [SUM_W-1:0]      entry_sum;
  logic [SUM_W-1:0]      entry_new;
  logic [SUM_W-1:0]      acc_add;
  logic [SUM_W-1:0]      result;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [MW-1:0]         wdata;

  assign walk_add  = (kind == KIND_ADD);
  assign active    = walk_add ? (idx < TSIZE) : (idx != '0);
  assign lowbit    = idx & (~idx + 1'b1);
  assign idx_step  = walk_add ? (idx + lowbit) : (idx - lowbit);
  assign rd_en     = (state == S_WALK) && active;
  assign walk_done = (state == S_WALK) && !active && !pend;
  assign slot_free = !out_valid || rsp.ready;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign clearing  = (state == S_CLEAR);

  // a stale stamp reads as an empty entry
  assign entry_sum = (rdata[MW-1:SUM_W] == epoch) ? rdata[SUM_W-1:0] : '0;
  assign entry_new = mod_add(entry_sum, amount);
  assign acc_add   = mod_add(acc, entry_sum);

  always_comb begin
    case (kind)
      KIND_PREFIX: result = acc;
      KIND_RANGE:  result = mod_sub(acc_r, acc);
      default:     result = '0;
    endcase
  end

  assign we    = clearing || ((state == S_WALK) && pend && walk_add);
  assign waddr = clearing ? cidx : widx;
  assign wdata = clearing ? '0 : {epoch, entry_new};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      epoch     <= '0;
      cidx      <= '0;
      pend      <= 1'b0;
      second    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= rd_en;
      if (state == S_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          cidx <= cidx + 1'b1;
          if (cidx == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            case (q_cmd.kind) inside
              KIND_CLEAR: begin
                epoch <= epoch + 1'b1;
                state <= S_DONE;
              end
              KIND_ADD, KIND_PREFIX, KIND_RANGE: begin
                second <= 1'b0;
                state  <= S_WALK;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_WALK: begin
          if (walk_done) begin
            if (kind == KIND_RANGE && !second) begin
              second <= 1'b1;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (slot_free) begin
            // wrap of the epoch: sweep every entry back to zero
            if (kind == KIND_CLEAR && epoch == '0) begin
              cidx  <= '0;
              state <= S_CLEAR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind   <= q_cmd.kind;
      amount <= q_cmd.amount;
      pos_b  <= q_cmd.pos_b;
      idx    <= IW'(q_cmd.pos_a);
      acc    <= '0;
    end else begin
      if (rd_en) begin
        widx <= idx[AW-1:0];
        idx  <= idx_step;
      end
      if (pend && !walk_add) begin
        acc <= acc_add;
      end
      // right end finished, start the walk from just left of the left end
      if (walk_done && kind == KIND_RANGE && !second) begin
        acc_r <= acc;
        acc   <= '0;
        idx   <= IW'(pos_b);
      end
    end
    if (state == S_DONE && slot_free) begin
      out_sum <= result;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.sum   = out_sum;

endmodule

// ===== rtl/fenwick_tree_modular_epoch_clear_core.sv =====
// ----------------------------------------------------------------------------
// fenwick_tree_modular_epoch_clear_core
// binary indexed tree of sums modulo 1000000007 with an epoch-stamped clear
// ----------------------------------------------------------------------------
// channel  dir  payload                                   word
// req      in   operation, position, low_position, amount  one operation
// rsp      out  sum                                       one result per req
//
// the walker does one tree step a cycle with one memory read a cycle;
// an add or prefix walks up to log2(TABLE_SIZE) steps, a range walks the
// right end and then the left end, each up to log2(TABLE_SIZE) steps, and
// a clear or an ignored add walks no steps.
// after rst and after an epoch wrap a sweep zeroes every memory entry;
// req.ready stays low meanwhile. a stalled rsp holds the walker, while the
// two-word command queue keeps taking requests until it is full.
// ----------------------------------------------------------------------------
`include "fenwick_tree_modular_epoch_clear_core_macros.svh"

module fenwick_tree_modular_epoch_clear_core import fwk_pkg::*; #(
  parameter int TABLE_SIZE = 1024,
  parameter int EPOCH_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  fwk_req_if.sink   req,
  fwk_rsp_if.source rsp
);

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_not_empty;
  logic     clearing;
  fwk_cmd_t push_cmd;
  fwk_cmd_t pop_cmd;

  fwk_front #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_front (
    .req      (req),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .cmd      (push_cmd)
  );

  fwk_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_not_empty)
  );

  fwk_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .EPOCH_BITS (EPOCH_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_not_empty),
    .q_cmd    (pop_cmd),
    .q_pop    (pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

  `FWK_ASSERT_IMPL(a_no_req_in_sweep, clearing, !req.ready)
  `FWK_ASSERT_IMPL(a_no_overflow, push, !q_full || pop)
  `FWK_ASSERT_IMPL(a_pop_nonempty, pop, q_not_empty)
  `FWK_ASSERT_NEXT(a_pop_spaced, pop, !pop)

endmodule
